/* design/zmwd_pkg.sv */
// Shared types and constants for the z-normalised minimum window distance block.
// Used by the controller, the datapath and its arithmetic units. No dependencies.
`timescale 1ns / 1ps

package zmwd_pkg;

    localparam int DATA_W  = 16;
    localparam int DIST_W  = 18;
    localparam int STAT_W  = 2;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int QUOT_W  = 33;
    localparam int FRAC_SH = 16;
    localparam int SQRT_ITER = RAD_W / 2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_SERIES = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_WINDOW = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FLAT      = 2'd2;

    typedef enum logic
    {
        SQ_SPREAD,
        SQ_QUOT
    } sqrt_sel_t;

    typedef enum logic [4:0]
    {
        S_IDLE,
        S_START,
        S_QSUM,
        S_QDRAIN,
        S_QMUL,
        S_QSUB,
        S_QTEST,
        S_QSQRT,
        S_WCHECK,
        S_WSUM,
        S_WDRAIN,
        S_WMUL,
        S_WSUB,
        S_WTEST,
        S_WSQRT,
        S_NUM,
        S_DIV,
        S_DIVW,
        S_DSQRT,
        S_DONE_FLAT,
        S_DONE
    } ctrl_state_t;

    typedef struct packed
    {
        logic      load;
        logic      q_mode;
        logic      rd_en;
        logic      k_clr;
        logic      acc_clr;
        logic      st_clr;
        logic      st_inc;
        logic      cap_qsum;
        logic      cap_mul;
        logic      cap_sub;
        logic      sqrt_start;
        sqrt_sel_t sqrt_sel;
        logic      cap_sxq;
        logic      cap_den;
        logic      cap_num;
        logic      div_start;
        logic      cap_best;
        logic      best_clr;
        logic      out_load;
        logic      out_flat;
    } dp_cmd_t;

    typedef struct packed
    {
        logic l_small;
        logic k_last;
        logic pipe_busy;
        logic syy_pos;
        logic win_ok;
        logic sqrt_busy;
        logic div_busy;
        logic out_free;
    } dp_stat_t;

endpackage

/* design/znorm_min_window_distance_core.sv */
// Z-normalised minimum window distance core.
// Loading: one sample word per cycle while idle; the final series word starts the search,
//   during which no word is taken. Search: query statistics (flat status if the query is
//   flat or under two samples), then each window, skipping those with no spread; the others
//   run the two 32-step square roots and the 33-step divider.
// Reset: asynchronous, active low; clears counters and control, stores stay undefined.
`timescale 1ns / 1ps

module znorm_min_window_distance_core #(
    parameter int QUERY_MAX  = 64,
    parameter int SERIES_MAX = 1024
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               cmd,
    input  logic signed [zmwd_pkg::DATA_W-1:0] sample,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [zmwd_pkg::DIST_W-1:0]        distance,
    output logic [zmwd_pkg::STAT_W-1:0]        status
);

    // command and status bundles between the sequencer and the datapath
    zmwd_pkg::dp_cmd_t  ctl;
    zmwd_pkg::dp_stat_t stat;

    // sequencer: takes words while idle, then walks query statistics and each window
    zmwd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .last     (last),
        .in_ready (in_ready),
        .ctl      (ctl),
        .stat     (stat)
    );

    // datapath: stores, sums, root and division units, held result word
    zmwd_datapath #(
        .QUERY_MAX  (QUERY_MAX),
        .SERIES_MAX (SERIES_MAX)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .cmd       (cmd),
        .sample    (sample),
        .last      (last),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .distance  (distance),
        .status    (status)
    );

endmodule

/* design/zmwd_sqrt.sv */
// Iterative integer square root, one result bit per cycle, with remainder.
// Depends on zmwd_pkg.
`timescale 1ns / 1ps

module zmwd_sqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [zmwd_pkg::RAD_W-1:0]  rad,
    output logic                        busy,
    output logic [zmwd_pkg::ROOT_W-1:0] root,
    output logic [zmwd_pkg::RAD_W-1:0]  rem
);

    localparam int CNT_W = $clog2(zmwd_pkg::SQRT_ITER);

    logic [zmwd_pkg::RAD_W-1:0] x_reg;
    logic [zmwd_pkg::RAD_W-1:0] r_reg;
    logic [zmwd_pkg::RAD_W-1:0] bit_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic [zmwd_pkg::RAD_W-1:0] trial;
    logic                       ge;

    assign trial = r_reg + bit_reg;
    assign ge    = x_reg >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(zmwd_pkg::SQRT_ITER - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= rad;
            r_reg   <= '0;
            bit_reg <= zmwd_pkg::RAD_W'(1) << (zmwd_pkg::RAD_W - 2);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                x_reg <= x_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = r_reg[zmwd_pkg::ROOT_W-1:0];
    assign rem  = x_reg;

endmodule

/* design/zmwd_div.sv */
// Restoring divider giving floor(num * 2^31 / den) for num <= 2 * den, one bit a cycle.
// Depends on zmwd_pkg.
`timescale 1ns / 1ps

module zmwd_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [zmwd_pkg::RAD_W-1:0]  num,
    input  logic [zmwd_pkg::RAD_W-1:0]  den,
    output logic                        busy,
    output logic [zmwd_pkg::QUOT_W-1:0] quot
);

    localparam int CNT_W = $clog2(zmwd_pkg::QUOT_W);

    logic [zmwd_pkg::RAD_W-1:0]  rem_reg;
    logic [zmwd_pkg::RAD_W-1:0]  den_reg;
    logic [zmwd_pkg::QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic [zmwd_pkg::RAD_W-1:0]  cmp;
    logic [zmwd_pkg::RAD_W-1:0]  cur;
    logic                        ge;

    // first step takes the bit worth two, second the bit worth one, then shift
    assign cmp = (cnt_reg == '0) ? (den_reg << 1) : den_reg;
    assign cur = (cnt_reg >= CNT_W'(2)) ? (rem_reg << 1) : rem_reg;
    assign ge  = cur >= cmp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(zmwd_pkg::QUOT_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? (cur - cmp) : cur;
            quot_reg <= {quot_reg[zmwd_pkg::QUOT_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

/* design/zmwd_datapath.sv */
// Datapath: sample stores, load counters, sum pipeline, correlation arithmetic,
// result register. Depends on zmwd_pkg, zmwd_sqrt and zmwd_div.
`timescale 1ns / 1ps

module zmwd_datapath #(
    parameter int QUERY_MAX  = 64,
    parameter int SERIES_MAX = 1024
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  zmwd_pkg::dp_cmd_t                  ctl,
    output zmwd_pkg::dp_stat_t                 stat,
    input  logic                               cmd,
    input  logic signed [zmwd_pkg::DATA_W-1:0] sample,
    input  logic                               last,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [zmwd_pkg::DIST_W-1:0]        distance,
    output logic [zmwd_pkg::STAT_W-1:0]        status
);

    localparam int DW    = zmwd_pkg::DATA_W;
    localparam int RW    = zmwd_pkg::RAD_W;
    localparam int QA    = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
    localparam int QCW   = $clog2(QUERY_MAX + 1);
    localparam int SA    = (SERIES_MAX > 1) ? $clog2(SERIES_MAX) : 1;
    localparam int SCW   = $clog2(SERIES_MAX + 1);
    localparam int CW    = ((SCW > QCW) ? SCW : QCW) + 1;
    localparam int SUM_W = DW + QCW;
    localparam int SQS_W = 2 * DW + QCW;
    localparam int P_W   = 2 * DW + 2 * QCW + 2;

    // load side
    logic [QCW-1:0] qcount_reg;
    logic           qclosed_reg;
    logic [SCW-1:0] scount_reg;
    logic [SCW-1:0] nlen_reg;
    logic [QCW-1:0] q_waddr;
    logic           q_wr;
    logic           s_wr;
    logic [SCW-1:0] s_next;

    assign q_waddr = qclosed_reg ? '0 : qcount_reg;
    assign q_wr    = ctl.load && (cmd == zmwd_pkg::CMD_QUERY) &&
                     (q_waddr < QCW'(QUERY_MAX));
    assign s_wr    = ctl.load && (cmd == zmwd_pkg::CMD_SERIES) &&
                     (scount_reg < SCW'(SERIES_MAX));
    assign s_next  = s_wr ? (scount_reg + SCW'(1)) : scount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcount_reg  <= '0;
            qclosed_reg <= 1'b0;
            scount_reg  <= '0;
            nlen_reg    <= '0;
        end
        else if (ctl.load)
        begin
            if (cmd == zmwd_pkg::CMD_QUERY)
            begin
                qcount_reg  <= q_wr ? (q_waddr + QCW'(1)) : q_waddr;
                qclosed_reg <= last;
            end
            else if (last)
            begin
                nlen_reg   <= s_next;
                scount_reg <= '0;
            end
            else
            begin
                scount_reg <= s_next;
            end
        end
    end

    // stores
    logic [DW-1:0]        query_mem [QUERY_MAX];
    logic [DW-1:0]        series_mem [SERIES_MAX];
    logic signed [DW-1:0] q_rdata_reg;
    logic signed [DW-1:0] s_rdata_reg;
    logic [QA-1:0]        k_reg;
    logic [SCW-1:0]       st_reg;
    logic [SCW-1:0]       s_raddr_full;

    assign s_raddr_full = st_reg + SCW'(k_reg);

    always_ff @(posedge clk)
    begin
        if (q_wr)
        begin
            query_mem[q_waddr[QA-1:0]] <= sample;
        end
        if (ctl.rd_en)
        begin
            q_rdata_reg <= query_mem[k_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_wr)
        begin
            series_mem[scount_reg[SA-1:0]] <= sample;
        end
        if (ctl.rd_en)
        begin
            s_rdata_reg <= series_mem[s_raddr_full[SA-1:0]];
        end
    end

    // sum pipeline control
    logic v1_reg;
    logic v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= '0;
            st_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.rd_en;
            v2_reg <= v1_reg;
            if (ctl.k_clr)
            begin
                k_reg <= '0;
            end
            else if (ctl.rd_en)
            begin
                k_reg <= k_reg + QA'(1);
            end
            if (ctl.st_clr)
            begin
                st_reg <= '0;
            end
            else if (ctl.st_inc)
            begin
                st_reg <= st_reg + SCW'(1);
            end
        end
    end

    // products then accumulation
    logic signed [DW-1:0]    w_sel;
    logic signed [2*DW-1:0]  ww_next;
    logic signed [2*DW-1:0]  wq_next;
    logic signed [2*DW-1:0]  ww_reg;
    logic signed [2*DW-1:0]  wq_reg;
    logic signed [DW-1:0]    wd_reg;
    logic signed [SUM_W-1:0] sw_reg;
    logic signed [SQS_W-1:0] sww_reg;
    logic signed [SQS_W-1:0] swq_reg;
    logic signed [SUM_W-1:0] sq_reg;

    assign w_sel   = ctl.q_mode ? q_rdata_reg : s_rdata_reg;
    assign ww_next = w_sel * w_sel;
    assign wq_next = w_sel * q_rdata_reg;

    always_ff @(posedge clk)
    begin
        ww_reg <= ww_next;
        wq_reg <= wq_next;
        wd_reg <= w_sel;
        if (ctl.acc_clr)
        begin
            sw_reg  <= '0;
            sww_reg <= '0;
            swq_reg <= '0;
        end
        else if (v2_reg)
        begin
            sw_reg  <= sw_reg + SUM_W'(wd_reg);
            sww_reg <= sww_reg + SQS_W'(ww_reg);
            swq_reg <= swq_reg + SQS_W'(wq_reg);
        end
        if (ctl.cap_qsum)
        begin
            sq_reg <= sw_reg;
        end
    end

    // spread and covariance terms
    logic signed [QCW:0]   lsig;
    logic signed [P_W-1:0] p1_reg;
    logic signed [P_W-1:0] p2_reg;
    logic signed [P_W-1:0] p3_reg;
    logic signed [P_W-1:0] p4_reg;
    logic signed [P_W-1:0] syy_reg;
    logic signed [P_W-1:0] sxy_reg;

    assign lsig = $signed({1'b0, qcount_reg});

    always_ff @(posedge clk)
    begin
        if (ctl.cap_mul)
        begin
            p1_reg <= P_W'(lsig * sww_reg);
            p2_reg <= P_W'(sw_reg * sw_reg);
            p3_reg <= P_W'(lsig * swq_reg);
            p4_reg <= P_W'(sw_reg * sq_reg);
        end
        if (ctl.cap_sub)
        begin
            syy_reg <= p1_reg - p2_reg;
            sxy_reg <= p3_reg - p4_reg;
        end
    end

    // square root shared by spread and quotient, and divider
    logic [RW-1:0]                     rad;
    logic                              sqrt_busy;
    logic [zmwd_pkg::ROOT_W-1:0]       root;
    logic [RW-1:0]                     sq_rem;
    logic                              div_busy;
    logic [zmwd_pkg::QUOT_W-1:0]       quot;

    assign rad = (ctl.sqrt_sel == zmwd_pkg::SQ_QUOT) ? (RW'(quot) << 2)
                                                    : (RW'($unsigned(syy_reg)) << zmwd_pkg::FRAC_SH);

    zmwd_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.sqrt_start),
        .rad   (rad),
        .busy  (sqrt_busy),
        .root  (root),
        .rem   (sq_rem)
    );

    logic [zmwd_pkg::ROOT_W-1:0] sxq_reg;
    logic [RW-1:0]               den_reg;
    logic [RW-1:0]               n_reg;
    logic [P_W-1:0]              mag;
    logic [RW-1:0]               pterm;
    logic [RW-1:0]               n_next;

    assign mag   = (sxy_reg < 0) ? $unsigned(-sxy_reg) : $unsigned(sxy_reg);
    assign pterm = RW'(mag) << zmwd_pkg::FRAC_SH;

    // numerator den - Sxy * 2^16, held within [0, 2 * den]
    always_comb
    begin
        if (sxy_reg >= 0)
        begin
            n_next = (pterm >= den_reg) ? '0 : (den_reg - pterm);
        end
        else
        begin
            n_next = (pterm > den_reg) ? (den_reg << 1) : (den_reg + pterm);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap_sxq)
        begin
            sxq_reg <= root;
        end
        if (ctl.cap_den)
        begin
            den_reg <= RW'(sxq_reg * root);
        end
        if (ctl.cap_num)
        begin
            n_reg <= n_next;
        end
    end

    zmwd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (n_reg),
        .den   (den_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

    // running minimum
    logic [zmwd_pkg::DIST_W-1:0] s_root;
    logic [zmwd_pkg::DIST_W-1:0] d_round;
    logic [zmwd_pkg::DIST_W-1:0] best_reg;
    logic                        found_reg;

    assign s_root  = root[zmwd_pkg::DIST_W-1:0];
    assign d_round = (sq_rem > RW'(s_root)) ? (s_root + zmwd_pkg::DIST_W'(1)) : s_root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.best_clr)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.cap_best)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.best_clr)
        begin
            best_reg <= zmwd_pkg::DIST_MAX;
        end
        else if (ctl.cap_best && (d_round < best_reg))
        begin
            best_reg <= d_round;
        end
    end

    // result register
    logic                        out_valid_reg;
    logic [zmwd_pkg::DIST_W-1:0] distance_reg;
    logic [zmwd_pkg::STAT_W-1:0] status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            if (ctl.out_flat)
            begin
                distance_reg <= zmwd_pkg::DIST_MAX;
                status_reg   <= zmwd_pkg::STATUS_FLAT;
            end
            else if (found_reg)
            begin
                distance_reg <= best_reg;
                status_reg   <= zmwd_pkg::STATUS_OK;
            end
            else
            begin
                distance_reg <= zmwd_pkg::DIST_MAX;
                status_reg   <= zmwd_pkg::STATUS_NO_WINDOW;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign status    = status_reg;

    assign stat.l_small   = qcount_reg < QCW'(2);
    assign stat.k_last    = (QCW'(k_reg) + QCW'(1)) == qcount_reg;
    assign stat.pipe_busy = v1_reg || v2_reg;
    assign stat.syy_pos   = syy_reg > 0;
    assign stat.win_ok    = (CW'(st_reg) + CW'(qcount_reg)) <= CW'(nlen_reg);
    assign stat.sqrt_busy = sqrt_busy;
    assign stat.div_busy  = div_busy;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

/* design/zmwd_ctrl.sv */
// Controller state machine: sequences loading, query statistics and the window search.
// Depends on zmwd_pkg.
`timescale 1ns / 1ps

module zmwd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 cmd,
    input  logic                 last,
    output logic                 in_ready,
    output zmwd_pkg::dp_cmd_t    ctl,
    input  zmwd_pkg::dp_stat_t   stat
);

    zmwd_pkg::ctrl_state_t state_reg;
    zmwd_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= zmwd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == zmwd_pkg::S_IDLE);
        unique case (state_reg)
            zmwd_pkg::S_IDLE:
            begin
                ctl.load = in_valid;
                if (in_valid && (cmd == zmwd_pkg::CMD_SERIES) && last)
                begin
                    state_next = zmwd_pkg::S_START;
                end
            end
            zmwd_pkg::S_START:
            begin
                ctl.best_clr = 1'b1;
                ctl.st_clr   = 1'b1;
                if (stat.l_small)
                begin
                    state_next = zmwd_pkg::S_DONE_FLAT;
                end
                else
                begin
                    ctl.k_clr   = 1'b1;
                    ctl.acc_clr = 1'b1;
                    state_next  = zmwd_pkg::S_QSUM;
                end
            end
            zmwd_pkg::S_QSUM:
            begin
                ctl.q_mode = 1'b1;
                ctl.rd_en  = 1'b1;
                if (stat.k_last)
                begin
                    state_next = zmwd_pkg::S_QDRAIN;
                end
            end
            zmwd_pkg::S_QDRAIN:
            begin
                ctl.q_mode = 1'b1;
                if (!stat.pipe_busy)
                begin
                    ctl.cap_qsum = 1'b1;
                    state_next   = zmwd_pkg::S_QMUL;
                end
            end
            zmwd_pkg::S_QMUL:
            begin
                ctl.cap_mul = 1'b1;
                state_next  = zmwd_pkg::S_QSUB;
            end
            zmwd_pkg::S_QSUB:
            begin
                ctl.cap_sub = 1'b1;
                state_next  = zmwd_pkg::S_QTEST;
            end
            zmwd_pkg::S_QTEST:
            begin
                if (!stat.syy_pos)
                begin
                    state_next = zmwd_pkg::S_DONE_FLAT;
                end
                else
                begin
                    ctl.sqrt_start = 1'b1;
                    ctl.sqrt_sel   = zmwd_pkg::SQ_SPREAD;
                    state_next     = zmwd_pkg::S_QSQRT;
                end
            end
            zmwd_pkg::S_QSQRT:
            begin
                if (!stat.sqrt_busy)
                begin
                    ctl.cap_sxq = 1'b1;
                    state_next  = zmwd_pkg::S_WCHECK;
                end
            end
            zmwd_pkg::S_WCHECK:
            begin
                if (stat.win_ok)
                begin
                    ctl.k_clr   = 1'b1;
                    ctl.acc_clr = 1'b1;
                    state_next  = zmwd_pkg::S_WSUM;
                end
                else
                begin
                    state_next = zmwd_pkg::S_DONE;
                end
            end
            zmwd_pkg::S_WSUM:
            begin
                ctl.rd_en = 1'b1;
                if (stat.k_last)
                begin
                    state_next = zmwd_pkg::S_WDRAIN;
                end
            end
            zmwd_pkg::S_WDRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = zmwd_pkg::S_WMUL;
                end
            end
            zmwd_pkg::S_WMUL:
            begin
                ctl.cap_mul = 1'b1;
                state_next  = zmwd_pkg::S_WSUB;
            end
            zmwd_pkg::S_WSUB:
            begin
                ctl.cap_sub = 1'b1;
                state_next  = zmwd_pkg::S_WTEST;
            end
            zmwd_pkg::S_WTEST:
            begin
                if (!stat.syy_pos)
                begin
                    ctl.st_inc = 1'b1;
                    state_next = zmwd_pkg::S_WCHECK;
                end
                else
                begin
                    ctl.sqrt_start = 1'b1;
                    ctl.sqrt_sel   = zmwd_pkg::SQ_SPREAD;
                    state_next     = zmwd_pkg::S_WSQRT;
                end
            end
            zmwd_pkg::S_WSQRT:
            begin
                if (!stat.sqrt_busy)
                begin
                    ctl.cap_den = 1'b1;
                    state_next  = zmwd_pkg::S_NUM;
                end
            end
            zmwd_pkg::S_NUM:
            begin
                ctl.cap_num = 1'b1;
                state_next  = zmwd_pkg::S_DIV;
            end
            zmwd_pkg::S_DIV:
            begin
                ctl.div_start = 1'b1;
                state_next    = zmwd_pkg::S_DIVW;
            end
            zmwd_pkg::S_DIVW:
            begin
                if (!stat.div_busy)
                begin
                    ctl.sqrt_start = 1'b1;
                    ctl.sqrt_sel   = zmwd_pkg::SQ_QUOT;
                    state_next     = zmwd_pkg::S_DSQRT;
                end
            end
            zmwd_pkg::S_DSQRT:
            begin
                if (!stat.sqrt_busy)
                begin
                    ctl.cap_best = 1'b1;
                    ctl.st_inc   = 1'b1;
                    state_next   = zmwd_pkg::S_WCHECK;
                end
            end
            zmwd_pkg::S_DONE_FLAT:
            begin
                if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    ctl.out_flat = 1'b1;
                    state_next   = zmwd_pkg::S_IDLE;
                end
            end
            zmwd_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = zmwd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = zmwd_pkg::S_IDLE;
            end
        endcase
    end

    a_sqrt_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.sqrt_start |-> !stat.sqrt_busy)
        else $error("square root restarted while busy");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_start |-> !stat.div_busy)
        else $error("divider restarted while busy");

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> stat.out_free)
        else $error("result overwritten before it was taken");

    a_read_query_len: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_en |-> !stat.l_small)
        else $error("window read with query shorter than two samples");

endmodule
